[sv/rpwc_pkg.sv]
// Package for the RC servo pulse width capture block.
// Holds channel count, field widths, register indexes, status codes and the result type.
// No dependencies.
package rpwc_pkg;

   localparam int NUM_CHANNELS = 3;
   localparam int CHAN_W       = 2;
   localparam int TICK_W       = 16;
   localparam int ROUND_W      = 8;
   localparam int STATUS_W     = 2;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 16;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] REG_TIMEOUT_TICKS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_WIDTH_TICKS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_RECHECK_ROUNDS  = 2'd2;

   // register reset values
   localparam logic [TICK_W-1:0]  TIMEOUT_RESET   = 16'd4352;
   localparam logic [TICK_W-1:0]  MAX_WIDTH_RESET = 16'd512;
   localparam logic [ROUND_W-1:0] RECHECK_RESET   = 8'd100;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_STORED    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_DISCARDED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_TIMEOUT   = 2'd2;

   typedef struct packed {
      logic [CHAN_W-1:0]       chan;
      logic [TICK_W-1:0]       width;
      logic [STATUS_W-1:0]     status;
      logic [NUM_CHANNELS-1:0] present_mask;
   } result_type;

endpackage

[sv/rc_pulse_width_capture.sv]
// Top level of the RC servo pulse width capture block.
// Per-tick measurement step, config registers and a two-deep result buffer.
// Depends on rpwc_pkg.
//
//   channel | ports                                   | direction
//   req     | req_valid req_stall req_pin_ch0..2       | in  (one timer tick per item)
//           | req_bus_access                          |
//   rsp     | rsp_valid rsp_stall rsp_chan rsp_width   | out (zero or one result per item)
//           | rsp_status rsp_present_mask             |
//   csr     | csr_write_enable csr_index csr_wdata     | in  (write only)
//
// One item per clock while req_stall is low: the measurement state updates in the
// cycle the tick is accepted, and its result goes to the result or skid register.
// A skid register behind the result register lets ticks keep flowing while a
// result waits; req_stall rises only when both are full.
// reset is synchronous; it restores the register defaults and the start state.
module rc_pulse_width_capture (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_pin_ch0,
   input  logic                                 req_pin_ch1,
   input  logic                                 req_pin_ch2,
   input  logic                                 req_bus_access,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [rpwc_pkg::CHAN_W-1:0]          rsp_chan,
   output logic [rpwc_pkg::TICK_W-1:0]          rsp_width,
   output logic [rpwc_pkg::STATUS_W-1:0]        rsp_status,
   output logic [rpwc_pkg::NUM_CHANNELS-1:0]    rsp_present_mask,
   input  logic                                 csr_write_enable,
   input  logic [rpwc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [rpwc_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int NCH = rpwc_pkg::NUM_CHANNELS;
   localparam int CW  = rpwc_pkg::CHAN_W;
   localparam int TW  = rpwc_pkg::TICK_W;
   localparam int RW  = rpwc_pkg::ROUND_W;

   // config registers
   logic [TW-1:0] timeout_ff;
   logic [TW-1:0] max_width_ff;
   logic [RW-1:0] recheck_ff;

   // measurement state
   logic [CW-1:0]  cur_chan_ff,  cur_chan_in;
   logic           measuring_ff, measuring_in;
   logic [TW-1:0]  tick_ff,      tick_in;
   logic           prev_ff,      prev_in;
   logic           discard_ff,   discard_in;
   logic [NCH-1:0] present_ff,   present_in;
   logic [RW-1:0]  round_ff,     round_in;

   // result buffer
   logic                 out_valid_ff, out_valid_in;
   rpwc_pkg::result_type out_ff,       out_in;
   logic                 skid_valid_ff, skid_valid_in;
   rpwc_pkg::result_type skid_ff,       skid_in;

   // step results before channel advance
   logic                 accept;
   logic [NCH-1:0]       pins;
   logic                 level;
   logic                 cur_present;
   logic [TW:0]          tick_inc;
   logic                 stp_measuring, stp_prev, stp_discard;
   logic [TW-1:0]        stp_tick;
   logic [NCH-1:0]       stp_present;
   logic                 do_advance, round_end_only;
   logic                 res_valid;
   rpwc_pkg::result_type res;

   // advance logic
   logic           found_after;
   logic [CW-1:0]  chan_after;
   logic           round_end;
   logic [NCH-1:0] flags_final;
   logic [CW-1:0]  chan_first;

   assign accept    = req_valid && !req_stall;
   assign req_stall = skid_valid_ff;
   assign pins      = {req_pin_ch2, req_pin_ch1, req_pin_ch0};
   assign tick_inc  = {1'b0, tick_ff} + {{TW{1'b0}}, 1'b1};

   always_comb begin
      level       = 1'b0;
      cur_present = 1'b0;
      for (int i = 0; i < NCH; i++) begin
         if (cur_chan_ff == CW'(i)) begin
            level       = pins[i];
            cur_present = present_ff[i];
         end
      end
   end

   // one tick of the current channel
   always_comb begin
      stp_measuring  = measuring_ff;
      stp_tick       = tick_ff;
      stp_prev       = prev_ff;
      stp_discard    = discard_ff;
      stp_present    = present_ff;
      do_advance     = 1'b0;
      round_end_only = 1'b0;
      res_valid      = 1'b0;
      res            = '0;
      res.chan       = cur_chan_ff;
      if (present_ff == '0) begin
         round_end_only = 1'b1;
      end else if (!cur_present) begin
         do_advance = 1'b1;
      end else begin
         stp_discard = discard_ff | req_bus_access;
         res.status  = stp_discard ? rpwc_pkg::STATUS_DISCARDED : rpwc_pkg::STATUS_STORED;
         if (!measuring_ff) begin
            if (!prev_ff && level) begin
               // rising edge: this tick is the first high tick
               stp_measuring = 1'b1;
               stp_tick      = TW'(1);
               stp_prev      = 1'b1;
               if (max_width_ff <= TW'(1)) begin
                  res_valid  = 1'b1;
                  res.width  = TW'(1);
                  do_advance = 1'b1;
               end
            end else begin
               stp_prev = level;
               stp_tick = tick_inc[TW-1:0];
               if (tick_inc >= {1'b0, timeout_ff}) begin
                  for (int i = 0; i < NCH; i++) begin
                     if (cur_chan_ff == CW'(i)) stp_present[i] = 1'b0;
                  end
                  res_valid  = 1'b1;
                  res.width  = '0;
                  res.status = rpwc_pkg::STATUS_TIMEOUT;
                  do_advance = 1'b1;
               end
            end
         end else if (!level) begin
            res_valid  = 1'b1;
            res.width  = tick_ff;
            do_advance = 1'b1;
         end else begin
            stp_tick = tick_inc[TW-1:0];
            if (tick_inc >= {1'b0, max_width_ff}) begin
               res_valid  = 1'b1;
               res.width  = tick_inc[TW-1:0];
               do_advance = 1'b1;
            end
         end
      end
      res.present_mask = stp_present;
   end

   // channel advance and round bookkeeping
   always_comb begin
      found_after = 1'b0;
      chan_after  = cur_chan_ff;
      for (int i = NCH - 1; i >= 0; i--) begin
         if (stp_present[i] && (CW'(i) > cur_chan_ff)) begin
            found_after = 1'b1;
            chan_after  = CW'(i);
         end
      end
      round_end   = round_end_only || (do_advance && !found_after);
      flags_final = stp_present;
      round_in    = round_ff;
      if (round_end) begin
         if (round_ff >= recheck_ff) begin
            round_in    = '0;
            flags_final = '1;
         end else begin
            round_in = round_ff + RW'(1);
         end
      end
      chan_first = '0;
      for (int i = NCH - 1; i >= 0; i--) begin
         if (flags_final[i]) chan_first = CW'(i);
      end

      cur_chan_in  = cur_chan_ff;
      measuring_in = stp_measuring;
      tick_in      = stp_tick;
      prev_in      = stp_prev;
      discard_in   = stp_discard;
      present_in   = flags_final;
      if (do_advance) begin
         cur_chan_in  = found_after ? chan_after : chan_first;
         measuring_in = 1'b0;
         tick_in      = '0;
         prev_in      = 1'b1;
         discard_in   = 1'b0;
      end
   end

   // result register with skid stage
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || !rsp_stall) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = accept && res_valid;
            out_in       = res;
         end
      end else if (accept && res_valid) begin
         skid_valid_in = 1'b1;
         skid_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff    <= rpwc_pkg::TIMEOUT_RESET;
         max_width_ff  <= rpwc_pkg::MAX_WIDTH_RESET;
         recheck_ff    <= rpwc_pkg::RECHECK_RESET;
         cur_chan_ff   <= '0;
         measuring_ff  <= 1'b0;
         tick_ff       <= '0;
         prev_ff       <= 1'b1;
         discard_ff    <= 1'b0;
         present_ff    <= '1;
         round_ff      <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               rpwc_pkg::REG_TIMEOUT_TICKS:   timeout_ff   <= csr_wdata[TW-1:0];
               rpwc_pkg::REG_MAX_WIDTH_TICKS: max_width_ff <= csr_wdata[TW-1:0];
               rpwc_pkg::REG_RECHECK_ROUNDS:  recheck_ff   <= csr_wdata[RW-1:0];
               default: ;
            endcase
         end
         if (accept) begin
            cur_chan_ff  <= cur_chan_in;
            measuring_ff <= measuring_in;
            tick_ff      <= tick_in;
            prev_ff      <= prev_in;
            discard_ff   <= discard_in;
            present_ff   <= present_in;
            round_ff     <= round_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_chan         = out_ff.chan;
   assign rsp_width        = out_ff.width;
   assign rsp_status       = out_ff.status;
   assign rsp_present_mask = out_ff.present_mask;

endmodule

[sv/rpwc_checker.sv]
// Port-level checks for the RC servo pulse width capture block, bound to its top level.
// Depends on rpwc_pkg and rc_pulse_width_capture.
module rpwc_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [rpwc_pkg::CHAN_W-1:0]       rsp_chan,
   input logic [rpwc_pkg::TICK_W-1:0]       rsp_width,
   input logic [rpwc_pkg::STATUS_W-1:0]     rsp_status,
   input logic [rpwc_pkg::NUM_CHANNELS-1:0] rsp_present_mask
);

   // nothing pending and input open right after reset
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("result or stall present after reset");

   a_timeout_width: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == rpwc_pkg::STATUS_TIMEOUT |-> rsp_width == '0)
      else $error("timeout item with nonzero width");

   // a timed-out channel is reported as absent in the same item
   a_timeout_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == rpwc_pkg::STATUS_TIMEOUT |-> !rsp_present_mask[rsp_chan])
      else $error("timed-out channel still marked present");

   a_pulse_width: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != rpwc_pkg::STATUS_TIMEOUT |-> rsp_width != '0)
      else $error("measured pulse with zero width");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_width) && $stable(rsp_chan))
      else $error("stalled result changed");

endmodule

bind rc_pulse_width_capture rpwc_checker u_rpwc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_chan         (rsp_chan),
   .rsp_width        (rsp_width),
   .rsp_status       (rsp_status),
   .rsp_present_mask (rsp_present_mask)
);
